// ===== hw/rtl/path_corridor_splice_macros.svh =====
// Assertion macros used by the path corridor splice top level.
`ifndef PATH_CORRIDOR_SPLICE_MACROS_SVH
`define PATH_CORRIDOR_SPLICE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PCS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcs: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcs: next-cycle check failed");

`endif

// ===== hw/rtl/pcs_pkg.sv =====
// Package with sizes, command codes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package pcs_pkg;

   localparam int MAX_PATH    = 256;
   localparam int MAX_VISITED = 16;

   localparam int REF_W   = 32;
   localparam int IDX_W   = 8;
   localparam int CMD_W   = 3;
   localparam int STAT_W  = 2;
   localparam int LEN_W   = 9;

   localparam int PATH_AW = $clog2(MAX_PATH);
   localparam int CNT_W   = $clog2(MAX_PATH + 1);
   localparam int VCNT_W  = $clog2(MAX_VISITED + 1);
   localparam int VIS_AW  = ($clog2(MAX_VISITED) > 0) ? $clog2(MAX_VISITED) : 1;
   localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int SUM_W   = ((CNT_W > VCNT_W) ? CNT_W : VCNT_W) + 1;

   localparam int REQ_DATA_W = ((REF_W + IDX_W + 7) / 8) * 8;
   localparam int RSP_BITS   = STAT_W + LEN_W + REF_W + 1;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [CMD_W-1:0] CMD_APPEND_PATH    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND_VISITED = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SPLICE         = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ           = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR          = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd2;

   // Strobes from the controller, one per datapath step.
   typedef struct packed {
      logic accept;
      logic read_done;
      logic scan_rd;
      logic scan_cmp;
      logic plan;
      logic move_rd;
      logic move_wr;
      logic fill;
   } pcs_cmd_type;

   // Conditions reported back by the datapath.
   typedef struct packed {
      logic out_free;
      logic in_read;
      logic in_scan;
      logic hit;
      logic scan_last;
      logic skip_move;
      logic move_last;
      logic fill_last;
   } pcs_stat_type;

endpackage
`default_nettype wire

// ===== hw/rtl/path_corridor_splice.sv =====
// Top level of the path corridor splice block: controller, datapath, checks.
// Usage:
//   req_* carries one command word: append to the path, append to the visited
//   list, splice, read one path entry, or clear both lists. rsp_* returns one
//   result word per command word, in order.
//   Append, clear and unused commands have their result registered at accept;
//   a read registers its result after one path memory read.
//   A splice reads, then compares, each path entry scanned from the end (memory
//   read, then compare against all visited entries at once), plans, reads and
//   writes each tail entry moved, and writes each reversed visited entry; the
//   result register loads with the last write, or with the last compare if no
//   entry matched. An empty list has its result registered at accept.
//   Throughput: one word per cycle for appends and clears while each result
//   is taken; the block takes no new word until the current result is loaded.
//   Reset empties both lists at once; no clearing pass is run.
//   A stalled receiver holds the result register, and req_tready stays low
//   until that result is taken or taken in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "path_corridor_splice_macros.svh"
module path_corridor_splice
   import pcs_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   // poly_ref [31:0], index [39:32]
   input  wire [REQ_DATA_W-1:0]  req_tdata,
   // command [2:0]
   input  wire [CMD_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   // status [1:0], path_length [10:2], read_ref [42:11], matched [43], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   pcs_cmd_type       cmd;
   pcs_stat_type      stat;
   logic [STAT_W-1:0] rsp_status;
   logic [LEN_W-1:0]  rsp_length;
   logic [REF_W-1:0]  rsp_read_ref;
   logic              rsp_matched;

   // Sequence each word through its steps.
   pcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Hold the stores, counters and result register.
   pcs_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_command  (req_tuser),
      .req_poly_ref (req_tdata[REF_W-1:0]),
      .req_index    (req_tdata[REF_W+IDX_W-1:REF_W]),
      .rsp_tready   (rsp_tready),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_tvalid),
      .rsp_status   (rsp_status),
      .rsp_length   (rsp_length),
      .rsp_read_ref (rsp_read_ref),
      .rsp_matched  (rsp_matched)
   );

   // Pack the result word, lowest field first, zeros above.
   assign rsp_tdata = RSP_DATA_W'({rsp_matched, rsp_read_ref, rsp_length, rsp_status});

   // Never take a word while an untaken result would be overwritten.
   `PCS_ASSERT_IMPLY(a_no_overrun, clock, reset, req_tvalid && req_tready,
                     !rsp_tvalid || rsp_tready)

   // A read needs the memory cycle: the port closes right after accept.
   `PCS_ASSERT_NEXT(a_read_blocks, clock, reset,
                    req_tvalid && req_tready && (req_tuser == CMD_READ), !req_tready)

   // An append answers in the next cycle.
   `PCS_ASSERT_NEXT(a_append_answers, clock, reset,
                    req_tvalid && req_tready && (req_tuser == CMD_APPEND_PATH), rsp_tvalid)

endmodule
`default_nettype wire

// ===== hw/rtl/pcs_ctrl.sv =====
// Controller state machine that sequences reads, scans, moves and fills.
`timescale 1ns / 1ps
`default_nettype none
module pcs_ctrl
   import pcs_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  pcs_stat_type stat,
   output pcs_cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_READ     = 8'b0000_0010,
      S_SCAN_RD  = 8'b0000_0100,
      S_SCAN_CMP = 8'b0000_1000,
      S_PLAN     = 8'b0001_0000,
      S_MOVE_RD  = 8'b0010_0000,
      S_MOVE_WR  = 8'b0100_0000,
      S_FILL     = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE) && stat.out_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd           = '0;
      cmd.accept    = accept;
      cmd.read_done = (state_ff == S_READ);
      cmd.scan_rd   = (state_ff == S_SCAN_RD);
      cmd.scan_cmp  = (state_ff == S_SCAN_CMP);
      cmd.plan      = (state_ff == S_PLAN);
      cmd.move_rd   = (state_ff == S_MOVE_RD);
      cmd.move_wr   = (state_ff == S_MOVE_WR);
      cmd.fill      = (state_ff == S_FILL);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && stat.in_read) begin
               state_in = S_READ;
            end else if (accept && stat.in_scan) begin
               state_in = S_SCAN_RD;
            end
         end
         S_READ:    state_in = S_IDLE;
         S_SCAN_RD: state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            if (stat.hit) begin
               state_in = S_PLAN;
            end else if (stat.scan_last) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_PLAN:    state_in = stat.skip_move ? S_FILL : S_MOVE_RD;
         S_MOVE_RD: state_in = S_MOVE_WR;
         S_MOVE_WR: state_in = stat.move_last ? S_FILL : S_MOVE_RD;
         S_FILL:    state_in = stat.fill_last ? S_IDLE : S_FILL;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/pcs_datapath.sv =====
// Datapath: path memory, visited list, scan and copy counters, result register.
`timescale 1ns / 1ps
`default_nettype none
module pcs_datapath
   import pcs_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire [CMD_W-1:0]   req_command,
   input  wire [REF_W-1:0]   req_poly_ref,
   input  wire [IDX_W-1:0]   req_index,
   input  wire               rsp_tready,
   input  pcs_cmd_type       cmd,
   output pcs_stat_type      stat,
   output logic              rsp_valid,
   output logic [STAT_W-1:0] rsp_status,
   output logic [LEN_W-1:0]  rsp_length,
   output logic [REF_W-1:0]  rsp_read_ref,
   output logic              rsp_matched
);

   logic [REF_W-1:0]   path_mem [MAX_PATH];
   logic [REF_W-1:0]   rdata_ff;
   logic [REF_W-1:0]   vis_ff [MAX_VISITED];

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [VCNT_W-1:0]  vcount_ff, vcount_in;
   logic [PATH_AW-1:0] p_ff, p_in;
   logic [PATH_AW-1:0] pos_ff, pos_in;
   logic [VIS_AW-1:0]  vsel_ff, vsel_in;
   logic               rd_ok_ff, rd_ok_in;
   logic [SUM_W-1:0]   req_ff, req_in;
   logic [SUM_W-1:0]   size_ff, size_in;
   logic [SUM_W-1:0]   orig_ff, orig_in;
   logic [SUM_W-1:0]   rem_ff, rem_in;
   logic [PATH_AW-1:0] off_ff, off_in;
   logic [PATH_AW-1:0] k_ff, k_in;
   logic               down_ff, down_in;

   logic               valid_ff, valid_in;
   logic [STAT_W-1:0]  status_ff;
   logic [LEN_W-1:0]   length_ff;
   logic [REF_W-1:0]   ref_ff;
   logic               match_ff;

   logic               mem_we;
   logic [PATH_AW-1:0] mem_wa, mem_ra;
   logic [REF_W-1:0]   mem_wd;
   logic               vis_we;
   logic [VIS_AW-1:0]  vis_wa;

   logic               out_load;
   logic [STAT_W-1:0]  out_status;
   logic [REF_W-1:0]   out_ref;
   logic               out_match;

   logic [MAX_VISITED-1:0] hit_vec;
   logic [VIS_AW-1:0]  hit_idx;
   logic [CMP_W-1:0]   idx_ext;
   logic [SUM_W-1:0]   req_c, orig_c, size_c, req_p, size_p;
   logic [SUM_W-1:0]   fill_vi, mv_src, mv_dst;

   // Match the word just read against every live visited entry; lowest wins.
   always_comb begin
      hit_idx = '0;
      for (int j = 0; j < MAX_VISITED; j++) begin
         hit_vec[j] = (VCNT_W'(j) < vcount_ff) && (vis_ff[j] == rdata_ff);
      end
      for (int j = MAX_VISITED - 1; j >= 0; j--) begin
         if (hit_vec[j]) begin
            hit_idx = VIS_AW'(j);
         end
      end
   end

   // Splice plan: prefix length, tail source and clamped tail size.
   always_comb begin
      req_c  = SUM_W'(vcount_ff) - SUM_W'(vsel_ff);
      orig_c = SUM_W'(pos_ff) + SUM_W'(1);
      size_c = SUM_W'(count_ff) - orig_c;
      req_p  = req_c;
      size_p = size_c;
      if (req_c >= SUM_W'(MAX_PATH)) begin
         req_p  = SUM_W'(MAX_PATH);
         size_p = '0;
      end else if (req_c + size_c > SUM_W'(MAX_PATH)) begin
         size_p = SUM_W'(MAX_PATH) - req_c;
      end
   end

   assign idx_ext = CMP_W'(req_index);
   assign fill_vi = SUM_W'(vcount_ff) - SUM_W'(1) - SUM_W'(k_ff);
   assign mv_src  = orig_ff + SUM_W'(off_ff);
   assign mv_dst  = req_ff + SUM_W'(off_ff);

   always_comb begin
      stat           = '0;
      stat.out_free  = !valid_ff || rsp_tready;
      stat.in_read   = (req_command == CMD_READ);
      stat.in_scan   = (req_command == CMD_SPLICE) && (count_ff != '0) && (vcount_ff != '0);
      stat.hit       = (hit_vec != '0);
      stat.scan_last = (p_ff == '0);
      stat.skip_move = (size_p == '0) || (req_p == orig_c);
      stat.move_last = (rem_ff == SUM_W'(1));
      stat.fill_last = (SUM_W'(k_ff) == req_ff - SUM_W'(1));
   end

   always_comb begin
      count_in   = count_ff;
      vcount_in  = vcount_ff;
      p_in       = p_ff;
      pos_in     = pos_ff;
      vsel_in    = vsel_ff;
      rd_ok_in   = rd_ok_ff;
      req_in     = req_ff;
      size_in    = size_ff;
      orig_in    = orig_ff;
      rem_in     = rem_ff;
      off_in     = off_ff;
      k_in       = k_ff;
      down_in    = down_ff;
      mem_we     = 1'b0;
      mem_wa     = '0;
      mem_wd     = '0;
      mem_ra     = '0;
      vis_we     = 1'b0;
      vis_wa     = '0;
      out_load   = 1'b0;
      out_status = ST_OK;
      out_ref    = '0;
      out_match  = 1'b0;

      if (cmd.accept) begin
         case (req_command)
            CMD_APPEND_PATH: begin
               out_load = 1'b1;
               if (count_ff >= CNT_W'(MAX_PATH)) begin
                  out_status = ST_FULL;
               end else begin
                  mem_we   = 1'b1;
                  mem_wa   = count_ff[PATH_AW-1:0];
                  mem_wd   = req_poly_ref;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_APPEND_VISITED: begin
               out_load = 1'b1;
               if (vcount_ff >= VCNT_W'(MAX_VISITED)) begin
                  out_status = ST_FULL;
               end else begin
                  vis_we    = 1'b1;
                  vis_wa    = vcount_ff[VIS_AW-1:0];
                  vcount_in = vcount_ff + VCNT_W'(1);
               end
            end
            CMD_SPLICE: begin
               if (stat.in_scan) begin
                  p_in = count_ff[PATH_AW-1:0] - PATH_AW'(1);
               end else begin
                  vcount_in = '0;
                  out_load  = 1'b1;
               end
            end
            CMD_READ: begin
               mem_ra   = idx_ext[PATH_AW-1:0];
               rd_ok_in = idx_ext < CMP_W'(count_ff);
            end
            CMD_CLEAR: begin
               count_in  = '0;
               vcount_in = '0;
               out_load  = 1'b1;
            end
            default: begin
               out_load = 1'b1;
            end
         endcase
      end

      if (cmd.read_done) begin
         out_load   = 1'b1;
         out_status = rd_ok_ff ? ST_OK : ST_BAD_INDEX;
         out_ref    = rd_ok_ff ? rdata_ff : '0;
      end

      if (cmd.scan_rd) begin
         mem_ra = p_ff;
      end

      if (cmd.scan_cmp) begin
         if (stat.hit) begin
            pos_in  = p_ff;
            vsel_in = hit_idx;
         end else if (stat.scan_last) begin
            vcount_in = '0;
            out_load  = 1'b1;
         end else begin
            p_in = p_ff - PATH_AW'(1);
         end
      end

      if (cmd.plan) begin
         req_in  = req_p;
         size_in = size_p;
         orig_in = orig_c;
         rem_in  = size_p;
         down_in = req_p > orig_c;
         off_in  = (req_p > orig_c) ? PATH_AW'(size_p - SUM_W'(1)) : '0;
         k_in    = '0;
      end

      if (cmd.move_rd) begin
         mem_ra = mv_src[PATH_AW-1:0];
      end

      if (cmd.move_wr) begin
         mem_we = 1'b1;
         mem_wa = mv_dst[PATH_AW-1:0];
         mem_wd = rdata_ff;
         rem_in = rem_ff - SUM_W'(1);
         off_in = down_ff ? off_ff - PATH_AW'(1) : off_ff + PATH_AW'(1);
      end

      if (cmd.fill) begin
         mem_we = 1'b1;
         mem_wa = k_ff;
         mem_wd = vis_ff[fill_vi[VIS_AW-1:0]];
         k_in   = k_ff + PATH_AW'(1);
         if (stat.fill_last) begin
            count_in  = CNT_W'(req_ff + size_ff);
            vcount_in = '0;
            out_load  = 1'b1;
            out_match = 1'b1;
         end
      end

      if (out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         path_mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= path_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (vis_we) begin
         vis_ff[vis_wa] <= req_poly_ref;
      end
      p_ff     <= p_in;
      pos_ff   <= pos_in;
      vsel_ff  <= vsel_in;
      rd_ok_ff <= rd_ok_in;
      req_ff   <= req_in;
      size_ff  <= size_in;
      orig_ff  <= orig_in;
      rem_ff   <= rem_in;
      off_ff   <= off_in;
      k_ff     <= k_in;
      down_ff  <= down_in;
      if (out_load) begin
         status_ff <= out_status;
         length_ff <= LEN_W'(count_in);
         ref_ff    <= out_ref;
         match_ff  <= out_match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         vcount_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         count_ff  <= count_in;
         vcount_ff <= vcount_in;
         valid_ff  <= valid_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_length   = length_ff;
   assign rsp_read_ref = ref_ff;
   assign rsp_matched  = match_ff;

endmodule
`default_nettype wire
